// ===== sv/nrn_pkg.sv =====
`default_nettype none

package nrn_pkg;

  // width of the degree field on the input stream
  localparam int DEG_W = 4;

  // bits of the multiplier operand taken per cycle by the shared multiplier
  localparam int CHUNK_W = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_NUM,
    ST_UPD,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== sv/nth_root_newton.sv =====
`default_nettype none

// Integer nth root by Newton iteration. Each beat on the slave side carries
// a radicand, a degree and a start guess that the user must keep nonzero;
// the block does not enforce this. One beat comes back with the floor of the
// root, an exact flag and a status bit that marks a zero start guess. One
// item is worked on at a time: s_tready is high only while the sequencer is
// idle. A finished result can still wait in the output register during that
// idle time. A zero start guess, a zero radicand or degree one goes straight
// to the output state. Otherwise each Newton step mostly runs the shared
// one-bit-per-cycle divider, which forms a / x^(d-1) and then the divide by
// d. The shared multiplier is 16 bits wide and works out each power x^(d-1).
// A power that passes the radicand ends its pass early and skips the first
// divide. There are k+2 steps: the first one, k descending ones and the one
// that stops, so the count depends on how far the start guess is from the
// root. A final power pass checks exactness.
module nth_root_newton #(
  parameter int DATA_WIDTH = 32,
  parameter int MAX_DEGREE = 15,
  localparam int S_W = ((2 * DATA_WIDTH + nrn_pkg::DEG_W + 7) / 8) * 8,
  localparam int M_W = ((DATA_WIDTH + 2 + 7) / 8) * 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output      logic           s_tready,
  // radicand, degree, start_guess (low bit up), zero fill above
  input  wire logic [S_W-1:0] s_tdata,
  output      logic           m_tvalid,
  input  wire logic           m_tready,
  // root, exact, status (low bit up), zero fill above
  output      logic [M_W-1:0] m_tdata
);

  localparam int W     = DATA_WIDTH;
  localparam int DW    = W + 1;
  localparam int CW    = nrn_pkg::CHUNK_W;
  localparam int NCH   = (W + CW - 1) / CW;
  localparam int XP    = NCH * CW;
  localparam int PW    = W + XP;
  localparam int CCW   = $clog2(NCH + 1);
  localparam int DCW   = $clog2(DW + 1);
  localparam int DEGW  = nrn_pkg::DEG_W;

  nrn_pkg::state_t state, state_next;

  logic [W-1:0]    a, a_next;
  logic [DEGW-1:0] deg, deg_next;
  logic [W-1:0]    x, x_next;
  logic [W-1:0]    p, p_next;
  logic [PW-1:0]   acc, acc_next;
  logic [XP-1:0]   mx, mx_next;
  logic [CCW-1:0]  cc, cc_next;
  logic [DEGW-1:0] ecnt, ecnt_next;
  logic            pow_exact, pow_exact_next;
  logic            first, first_next;
  logic [W-1:0]    rem, rem_next;
  logic [DW-1:0]   quo, quo_next;
  logic [W-1:0]    dvs, dvs_next;
  logic [DCW-1:0]  dcnt, dcnt_next;
  logic            div_by_d, div_by_d_next;
  logic [W-1:0]    qv, qv_next;
  logic            sub, sub_next;
  logic            exact_p, exact_p_next;
  logic            status_p, status_p_next;
  logic            m_tvalid_next;
  logic [W-1:0]    out_root, out_root_next;
  logic            out_exact, out_exact_next;
  logic            out_status, out_status_next;

  logic [W-1:0]    in_a;
  logic [DEGW-1:0] in_deg;
  logic [W-1:0]    in_x;
  logic [DEGW-1:0] dz;
  logic [W+CW-1:0] prod;
  logic [DW-1:0]   trial;
  logic [DW-1:0]   diff;
  logic            ge;
  logic [W-1:0]    nx;
  logic            over;

  assign in_a   = s_tdata[W-1:0];
  assign in_deg = s_tdata[W+DEGW-1:W];
  assign in_x   = s_tdata[2*W+DEGW-1:W+DEGW];

  assign s_tready = (state == nrn_pkg::ST_IDLE);
  assign m_tdata  = M_W'({out_status, out_exact, out_root});

  // shared datapath pieces
  assign prod  = p * mx[XP-1 -: CW];
  assign trial = {rem, quo[DW-1]};
  assign diff  = trial - DW'(dvs);
  assign ge    = (trial >= DW'(dvs));
  assign nx    = sub ? (x - quo[W-1:0]) : (x + quo[W-1:0]);
  assign over  = (acc > PW'(a));

  always_comb begin
    dz = (in_deg == '0) ? DEGW'(1) : in_deg;
    if (int'(dz) > MAX_DEGREE) begin
      dz = DEGW'(MAX_DEGREE);
    end
  end

  always_comb begin
    state_next      = state;
    a_next          = a;
    deg_next        = deg;
    x_next          = x;
    p_next          = p;
    acc_next        = acc;
    mx_next         = mx;
    cc_next         = cc;
    ecnt_next       = ecnt;
    pow_exact_next  = pow_exact;
    first_next      = first;
    rem_next        = rem;
    quo_next        = quo;
    dvs_next        = dvs;
    dcnt_next       = dcnt;
    div_by_d_next   = div_by_d;
    qv_next         = qv;
    sub_next        = sub;
    exact_p_next    = exact_p;
    status_p_next   = status_p;
    m_tvalid_next   = m_tvalid && !m_tready;
    out_root_next   = out_root;
    out_exact_next  = out_exact;
    out_status_next = out_status;

    unique case (state)
      nrn_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          a_next        = in_a;
          deg_next      = dz;
          x_next        = in_x;
          exact_p_next  = 1'b1;
          status_p_next = 1'b0;
          first_next    = 1'b1;
          priority if (in_x == '0) begin
            x_next        = '0;
            exact_p_next  = 1'b0;
            status_p_next = 1'b1;
            state_next    = nrn_pkg::ST_OUT;
          end else if (in_a == '0) begin
            x_next     = '0;
            state_next = nrn_pkg::ST_OUT;
          end else if (dz == DEGW'(1)) begin
            x_next     = in_a;
            state_next = nrn_pkg::ST_OUT;
          end else begin
            // first power pass of the first step
            pow_exact_next = 1'b0;
            p_next         = W'(1);
            ecnt_next      = dz - DEGW'(1);
            acc_next       = '0;
            mx_next        = XP'(in_x);
            cc_next        = CCW'(NCH);
            state_next     = nrn_pkg::ST_MUL;
          end
        end
      end

      nrn_pkg::ST_MUL: begin
        // most significant chunk first, shift-and-add into acc
        acc_next = {acc[PW-CW-1:0], {CW{1'b0}}} + PW'(prod);
        mx_next  = {mx[XP-CW-1:0], {CW{1'b0}}};
        cc_next  = cc - CCW'(1);
        if (cc == CCW'(1)) begin
          state_next = nrn_pkg::ST_CHK;
        end
      end

      nrn_pkg::ST_CHK: begin
        p_next = acc[W-1:0];
        priority if (over) begin
          if (pow_exact) begin
            exact_p_next = 1'b0;
            state_next   = nrn_pkg::ST_OUT;
          end else begin
            qv_next    = '0;
            state_next = nrn_pkg::ST_NUM;
          end
        end else if (ecnt == DEGW'(1)) begin
          if (pow_exact) begin
            exact_p_next = (acc[W-1:0] == a);
            state_next   = nrn_pkg::ST_OUT;
          end else begin
            // a divided by the power
            rem_next      = '0;
            quo_next      = DW'(a);
            dvs_next      = acc[W-1:0];
            dcnt_next     = DCW'(DW);
            div_by_d_next = 1'b0;
            state_next    = nrn_pkg::ST_DIV;
          end
        end else begin
          ecnt_next  = ecnt - DEGW'(1);
          acc_next   = '0;
          mx_next    = XP'(x);
          cc_next    = CCW'(NCH);
          state_next = nrn_pkg::ST_MUL;
        end
      end

      nrn_pkg::ST_DIV: begin
        rem_next  = ge ? diff[W-1:0] : trial[W-1:0];
        quo_next  = {quo[DW-2:0], ge};
        dcnt_next = dcnt - DCW'(1);
        if (dcnt == DCW'(1)) begin
          if (div_by_d) begin
            state_next = nrn_pkg::ST_UPD;
          end else begin
            qv_next    = quo_next[W-1:0];
            state_next = nrn_pkg::ST_NUM;
          end
        end
      end

      nrn_pkg::ST_NUM: begin
        // round the new x down on both sides of x
        sub_next = (qv <= x);
        if (qv <= x) begin
          quo_next = DW'(x) - DW'(qv) + DW'(deg) - DW'(1);
        end else begin
          quo_next = DW'(qv - x);
        end
        rem_next      = '0;
        dvs_next      = W'(deg);
        dcnt_next     = DCW'(DW);
        div_by_d_next = 1'b1;
        state_next    = nrn_pkg::ST_DIV;
      end

      nrn_pkg::ST_UPD: begin
        acc_next   = '0;
        cc_next    = CCW'(NCH);
        p_next     = W'(1);
        state_next = nrn_pkg::ST_MUL;
        if (!first && (nx >= x)) begin
          // converged, check root^d against the radicand
          pow_exact_next = 1'b1;
          ecnt_next      = deg;
          mx_next        = XP'(x);
        end else begin
          first_next     = 1'b0;
          x_next         = nx;
          pow_exact_next = 1'b0;
          ecnt_next      = deg - DEGW'(1);
          mx_next        = XP'(nx);
        end
      end

      nrn_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next   = 1'b1;
          out_root_next   = x;
          out_exact_next  = exact_p;
          out_status_next = status_p;
          state_next      = nrn_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = nrn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= nrn_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    a          <= a_next;
    deg        <= deg_next;
    x          <= x_next;
    p          <= p_next;
    acc        <= acc_next;
    mx         <= mx_next;
    cc         <= cc_next;
    ecnt       <= ecnt_next;
    pow_exact  <= pow_exact_next;
    first      <= first_next;
    rem        <= rem_next;
    quo        <= quo_next;
    dvs        <= dvs_next;
    dcnt       <= dcnt_next;
    div_by_d   <= div_by_d_next;
    qv         <= qv_next;
    sub        <= sub_next;
    exact_p    <= exact_p_next;
    status_p   <= status_p_next;
    out_root   <= out_root_next;
    out_exact  <= out_exact_next;
    out_status <= out_status_next;
  end

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == nrn_pkg::ST_DIV) |-> (dcnt != '0))
    else $error("divider running with zero bit count");

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    (state == nrn_pkg::ST_MUL) |-> (cc != '0))
    else $error("multiplier running with zero chunk count");

  a_pow_count: assert property (@(posedge clk) disable iff (rst)
    (state == nrn_pkg::ST_CHK) |-> (ecnt != '0))
    else $error("power check with zero exponent count");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == nrn_pkg::ST_OUT && (!m_tvalid || m_tready))
      |=> (m_tvalid && state == nrn_pkg::ST_IDLE))
    else $error("result not loaded into output register");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status) |-> (out_root == '0 && !out_exact))
    else $error("rejected beat carries a root or exact flag");

endmodule

`default_nettype wire
